/* rtl/core/cvd_pkg.sv */
// Shared constants, types and coefficient tables for the dichromacy simulator.
package cvd_pkg;

   localparam int COEF_FRAC_BITS  = 14;
   localparam int INTER_FRAC_BITS = 8;

   localparam int NUM_STAGES   = 5;
   localparam int CELL_LATENCY = 2;
   localparam int PIPE_DEPTH   = NUM_STAGES * CELL_LATENCY + 1;

   localparam int PIX_W   = 8;
   localparam int MODE_W  = 2;
   localparam int STAGE_W = $clog2(NUM_STAGES);
   // coefficients stay below 2.1 in magnitude
   localparam int COEF_W  = COEF_FRAC_BITS + 3;
   // integer part stays below 2^15 at every stage
   localparam int DATA_W  = INTER_FRAC_BITS + 16;
   localparam int PROD_W  = DATA_W + COEF_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int SHIFT_W = $clog2(COEF_FRAC_BITS + INTER_FRAC_BITS + 1);

   localparam int PIX_MAX = (1 << PIX_W) - 1;

   typedef logic [MODE_W-1:0]          mode_type;
   typedef logic [STAGE_W-1:0]         stage_type;
   typedef logic [PIX_W-1:0]           pix_type;
   typedef logic [SHIFT_W-1:0]         shift_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [DATA_W-1:0]   data_type;
   typedef data_type [2:0]             vec_type;

   // valid and mode travel together down the chain
   typedef struct packed {
      logic     valid;
      mode_type mode;
   } ctl_type;

   localparam mode_type MODE_DEUTAN = 2'd0;
   localparam mode_type MODE_PROTAN = 2'd1;
   localparam mode_type MODE_TRITAN = 2'd2;
   localparam mode_type MODE_UNUSED = 2'd3;

   localparam stage_type STAGE_RGB_XYZ = STAGE_W'(0);
   localparam stage_type STAGE_XYZ_LMS = STAGE_W'(1);
   localparam stage_type STAGE_CONE    = STAGE_W'(2);
   localparam stage_type STAGE_LMS_XYZ = STAGE_W'(3);
   localparam stage_type STAGE_XYZ_RGB = STAGE_W'(4);

   // four-place decimal (scaled by 10000) to fixed point, round half away from zero
   function automatic int q4(int c4);
      longint mag;
      mag = (c4 < 0) ? -longint'(c4) : longint'(c4);
      mag = (mag * (longint'(1) << COEF_FRAC_BITS) + 5000) / 10000;
      return (c4 < 0) ? -int'(mag) : int'(mag);
   endfunction

   localparam int Q_RGB_XYZ [9] = '{
      q4(5767), q4(1855), q4(1881),
      q4(2973), q4(6273), q4(752),
      q4(270),  q4(706),  q4(9911)};

   localparam int Q_XYZ_LMS [9] = '{
      q4(2105),  q4(8550),  q4(-396),
      q4(-4170), q4(11772), q4(786),
      q4(0),     q4(0),     q4(5168)};

   localparam int Q_CONE [3][9] = '{
      '{q4(10000), q4(0), q4(0), q4(11010), q4(0), q4(-90), q4(0), q4(0), q4(10000)},
      '{q4(0), q4(9082), q4(81), q4(0), q4(10000), q4(0), q4(0), q4(0), q4(10000)},
      '{q4(10000), q4(0), q4(0), q4(0), q4(10000), q4(0), q4(-1577), q4(11946), q4(0)}};

   localparam int Q_LMS_XYZ [3][9] = '{
      '{q4(19479), q4(-14147), q4(-3644), q4(6900), q4(3483), q4(-1),
        q4(0), q4(0), q4(19349)},
      '{q4(19473), q4(-14144), q4(-3647), q4(6899), q4(3483), q4(0),
        q4(0), q4(0), q4(19348)},
      '{q4(19473), q4(-14144), q4(-3647), q4(6899), q4(3483), q4(0),
        q4(0), q4(0), q4(19348)}};

   localparam int Q_XYZ_RGB [9] = '{
      q4(20413), q4(-5649), q4(-3446),
      q4(-9692), q4(18760), q4(415),
      q4(134),   q4(-1183), q4(10154)};

   // coefficient k (row * 3 + column) of a stage's matrix
   function automatic coef_type coef_at(stage_type s, mode_type m, int k);
      int mi;
      int q;
      mi = (m == MODE_UNUSED) ? 0 : int'(m);
      case (s)
         STAGE_RGB_XYZ: q = Q_RGB_XYZ[k];
         STAGE_XYZ_LMS: q = Q_XYZ_LMS[k];
         STAGE_CONE:    q = Q_CONE[mi][k];
         STAGE_LMS_XYZ: q = Q_LMS_XYZ[mi][k];
         default:       q = Q_XYZ_RGB[k];
      endcase
      return COEF_W'(q);
   endfunction

   // fraction bits of the sum minus fraction bits wanted after the stage
   function automatic int shift_diff(stage_type s, mode_type m);
      int fi;
      int fin;
      int fout;
      fi   = (m == MODE_DEUTAN) ? INTER_FRAC_BITS : 0;
      fin  = (s == STAGE_RGB_XYZ) ? 0 : fi;
      fout = (s == STAGE_XYZ_RGB) ? 0 : fi;
      return fin + COEF_FRAC_BITS - fout;
   endfunction

   function automatic shift_type shift_right_at(stage_type s, mode_type m);
      int d;
      d = shift_diff(s, m);
      return (d > 0) ? SHIFT_W'(d) : '0;
   endfunction

   function automatic shift_type shift_left_at(stage_type s, mode_type m);
      int d;
      d = shift_diff(s, m);
      return (d < 0) ? SHIFT_W'(-d) : '0;
   endfunction

endpackage

/* rtl/core/cvd_channels.sv */
// Valid/ready channel interfaces for source pixels and simulated pixels.
interface cvd_req_if;
   import cvd_pkg::*;

   logic    valid;
   logic    ready;
   pix_type red_in;
   pix_type green_in;
   pix_type blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink   (input valid, input red_in, input green_in, input blue_in,
                   output ready);
endinterface

interface cvd_rsp_if;
   import cvd_pkg::*;

   logic    valid;
   logic    ready;
   pix_type red_out;
   pix_type green_out;
   pix_type blue_out;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   output ready);
endinterface

/* rtl/core/color_vision_deficiency_sim.sv */
// Dichromacy simulation of an RGB pixel stream: a chain of five matrix cells.
// In steady state one pixel per clock enters and leaves while rsp_ch.ready is high; each
// pixel passes through two register levels in each of the five matrix cells
// (RGB->XYZ, XYZ->LMS, cone replacement, LMS->XYZ, XYZ->RGB) plus the clamped output
// register. Every register level stalls on its own, so bubbles close up under
// back-pressure and req_ch.ready stays high while any level of the chain is empty.
// csr_wr_data selects the mode (0 deuteranopia, 1 protanopia, 2 tritanopia); a write
// of 3 is ignored. Change the mode only while no item is in flight.
module color_vision_deficiency_sim (
   input  logic               clock,
   input  logic               reset,
   cvd_req_if.sink            req_ch,
   cvd_rsp_if.source          rsp_ch,
   input  logic               csr_wr_en,
   input  cvd_pkg::mode_type  csr_wr_data
);
   import cvd_pkg::*;

   mode_type mode_ff, mode_in;
   ctl_type  link_ctl   [NUM_STAGES+1];
   vec_type  link_data  [NUM_STAGES+1];
   logic     link_ready [NUM_STAGES+1];

   logic     out_valid_ff, out_valid_in;
   pix_type  red_ff, green_ff, blue_ff;

   function automatic pix_type clamp_pix(data_type v);
      if (v < 0) begin
         return '0;
      end else if (v > data_type'(PIX_MAX)) begin
         return pix_type'(PIX_MAX);
      end else begin
         return v[PIX_W-1:0];
      end
   endfunction

   assign mode_in = (csr_wr_en && csr_wr_data != MODE_UNUSED) ? csr_wr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DEUTAN;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // pixel enters as an integer, no fraction bits
   assign link_ctl[0].valid = req_ch.valid;
   assign link_ctl[0].mode  = mode_ff;
   assign link_data[0][0]   = DATA_W'(req_ch.red_in);
   assign link_data[0][1]   = DATA_W'(req_ch.green_in);
   assign link_data[0][2]   = DATA_W'(req_ch.blue_in);
   assign req_ch.ready      = link_ready[0];

   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_cell
      cvd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_id  (stage_type'(k)),
         .in_ctl    (link_ctl[k]),
         .in_data   (link_data[k]),
         .in_ready  (link_ready[k]),
         .out_ctl   (link_ctl[k+1]),
         .out_data  (link_data[k+1]),
         .out_ready (link_ready[k+1])
      );
   end

   assign link_ready[NUM_STAGES] = !out_valid_ff || rsp_ch.ready;
   assign out_valid_in = link_ready[NUM_STAGES] ? link_ctl[NUM_STAGES].valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (link_ready[NUM_STAGES]) begin
         red_ff   <= clamp_pix(link_data[NUM_STAGES][0]);
         green_ff <= clamp_pix(link_data[NUM_STAGES][1]);
         blue_ff  <= clamp_pix(link_data[NUM_STAGES][2]);
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.red_out   = red_ff;
   assign rsp_ch.green_out = green_ff;
   assign rsp_ch.blue_out  = blue_ff;

`ifndef ASSERT_OFF
   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_UNUSED)
      else $error("unused mode code reached the mode register");

   a_out_from_chain: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(link_ctl[NUM_STAGES].valid))
      else $error("output item appeared without one leaving the last cell");

   a_out_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !link_ctl[NUM_STAGES].valid) |=> !rsp_ch.valid)
      else $error("delivered item shown again");
`endif

endmodule

/* rtl/core/cvd_cell.sv */
// One 3x3 matrix cell: registered products, then sum and truncating rescale.
module cvd_cell (
   input  logic              clock,
   input  logic              reset,
   input  cvd_pkg::stage_type stage_id,
   input  cvd_pkg::ctl_type  in_ctl,
   input  cvd_pkg::vec_type  in_data,
   output logic              in_ready,
   output cvd_pkg::ctl_type  out_ctl,
   output cvd_pkg::vec_type  out_data,
   input  logic              out_ready
);
   import cvd_pkg::*;

   logic                     va_ff, va_in;
   logic                     vb_ff, vb_in;
   mode_type                 mode_a_ff;
   mode_type                 mode_b_ff;
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [PROD_W-1:0] prod_in [3][3];
   vec_type                  data_b_ff, data_b_in;
   logic                     rdy_a, rdy_b;

   assign rdy_b    = !vb_ff || out_ready;
   assign rdy_a    = !va_ff || rdy_b;
   assign in_ready = rdy_a;

   assign va_in = rdy_a ? in_ctl.valid : va_ff;
   assign vb_in = rdy_b ? va_ff : vb_ff;

   always_comb begin
      logic signed [PROD_W-1:0] a_ext;
      logic signed [PROD_W-1:0] c_ext;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            a_ext = PROD_W'(in_data[j]);
            c_ext = PROD_W'(coef_at(stage_id, in_ctl.mode, i * 3 + j));
            prod_in[i][j] = a_ext * c_ext;
         end
      end
   end

   // sum of a row, then rescale with truncation toward zero
   always_comb begin
      logic signed [ACC_W-1:0] acc;
      logic [ACC_W-1:0]        mag;
      logic [ACC_W-1:0]        scaled;
      logic [ACC_W-1:0]        res;
      shift_type               rs;
      shift_type               ls;
      rs = shift_right_at(stage_id, mode_a_ff);
      ls = shift_left_at(stage_id, mode_a_ff);
      for (int i = 0; i < 3; i++) begin
         acc    = ACC_W'(prod_ff[i][0]) + ACC_W'(prod_ff[i][1]) + ACC_W'(prod_ff[i][2]);
         mag    = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
         scaled = (mag >> rs) << ls;
         res    = acc[ACC_W-1] ? ACC_W'(-scaled) : scaled;
         data_b_in[i] = res[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         prod_ff   <= prod_in;
         mode_a_ff <= in_ctl.mode;
      end
      if (rdy_b) begin
         data_b_ff <= data_b_in;
         mode_b_ff <= mode_a_ff;
      end
   end

   assign out_ctl.valid = vb_ff;
   assign out_ctl.mode  = mode_b_ff;
   assign out_data      = data_b_ff;

`ifndef ASSERT_OFF
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (vb_ff && !out_ready) |=> (vb_ff && $stable(data_b_ff) && $stable(mode_b_ff)))
      else $error("cell result changed while stalled");

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !vb_ff |-> in_ready)
      else $error("cell refused an item with its result stage empty");
`endif

endmodule
